// ===== sv/skrf_pkg.sv =====
// Shared constants, register codes, types and a saturation helper for the rate fusion filter.
`default_nettype none
package skrf_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int VAR_WIDTH  = DATA_WIDTH - 1;
   localparam int SUM_WIDTH  = DATA_WIDTH + 2;
   localparam int GAIN_WIDTH = FRAC_BITS + 1;
   localparam int MAG_WIDTH  = DATA_WIDTH + 1;
   localparam int PROD_WIDTH = MAG_WIDTH + GAIN_WIDTH;
   localparam int ADDR_WIDTH = 2;

   localparam logic [VAR_WIDTH-1:0] INIT_VAR_RESET = VAR_WIDTH'(65536000);
   localparam logic [VAR_WIDTH-1:0] MEAS_NOISE_RESET = VAR_WIDTH'(32768);
   localparam logic [VAR_WIDTH-1:0] PROC_NOISE_RESET = VAR_WIDTH'(262144);

   localparam logic [ADDR_WIDTH-1:0] REG_INIT_VAR   = 2'd0;
   localparam logic [ADDR_WIDTH-1:0] REG_MEAS_NOISE = 2'd1;
   localparam logic [ADDR_WIDTH-1:0] REG_PROC_NOISE = 2'd2;

   localparam logic OP_ODOMETRY = 1'b0;
   localparam logic OP_GYRO     = 1'b1;

   typedef logic signed [DATA_WIDTH-1:0] rate_type;
   typedef logic [VAR_WIDTH-1:0] var_type;

   function automatic rate_type sat_rate(input logic signed [SUM_WIDTH-1:0] v);
      logic signed [SUM_WIDTH-1:0] hi;
      logic signed [SUM_WIDTH-1:0] lo;
      hi = SUM_WIDTH'({1'b0, {(DATA_WIDTH-1){1'b1}}});
      lo = -hi - SUM_WIDTH'(1);
      if (v > hi) begin
         return {1'b0, {(DATA_WIDTH-1){1'b1}}};
      end else if (v < lo) begin
         return {1'b1, {(DATA_WIDTH-1){1'b0}}};
      end
      return v[DATA_WIDTH-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== sv/skrf_if.sv =====
// Valid/ready channel interfaces for the sample, result and register write channels.
`default_nettype none
interface skrf_req_if;
   logic valid;
   logic ready;
   logic opcode;
   logic signed [skrf_pkg::DATA_WIDTH-1:0] rate_sample;
   modport source(output valid, output opcode, output rate_sample, input ready);
   modport sink(input valid, input opcode, input rate_sample, output ready);
endinterface

interface skrf_rsp_if;
   logic valid;
   logic ready;
   logic signed [skrf_pkg::DATA_WIDTH-1:0] filtered_rate;
   logic [skrf_pkg::VAR_WIDTH-1:0] estimate_variance;
   modport source(output valid, output filtered_rate, output estimate_variance, input ready);
   modport sink(input valid, input filtered_rate, input estimate_variance, output ready);
endinterface

interface skrf_csr_if;
   logic valid;
   logic ready;
   logic [skrf_pkg::ADDR_WIDTH-1:0] addr;
   logic [skrf_pkg::VAR_WIDTH-1:0] wdata;
   modport source(output valid, output addr, output wdata, input ready);
   modport sink(input valid, input addr, input wdata, output ready);
endinterface
`default_nettype wire

// ===== sv/scalar_kalman_rate_fusion.sv =====
// Scalar Kalman filter fusing odometry and gyro yaw rates with one shared multiplier.
// Gyro beats and the first odometry beat are absorbed in the cycle they are accepted.
// A later odometry beat passes through a prepare state, 17 divider steps, two passes through
// the shared multiplier and an apply state, held while the result slot is full, that shows it.
// No new beat is taken until the block is back in idle, so beats never overlap in flight.
// Synchronous active-high reset restores register defaults and the filter state.
`default_nettype none
module scalar_kalman_rate_fusion (
   input  wire logic clock,
   input  wire logic reset,
   skrf_req_if.sink  req_if,
   skrf_rsp_if.source rsp_if,
   skrf_csr_if.sink  csr_if
);

   localparam int DW = skrf_pkg::DATA_WIDTH;
   localparam int VW = skrf_pkg::VAR_WIDTH;
   localparam int FB = skrf_pkg::FRAC_BITS;
   localparam int SW = skrf_pkg::SUM_WIDTH;
   localparam int GW = skrf_pkg::GAIN_WIDTH;
   localparam int MW = skrf_pkg::MAG_WIDTH;
   localparam int PW = skrf_pkg::PROD_WIDTH;
   localparam int DIV_STEPS = FB + 1;
   localparam int CW = $clog2(DIV_STEPS);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PREP  = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_MVAR  = 3'd3;
   localparam logic [2:0] S_MCORR = 3'd4;
   localparam logic [2:0] S_APPLY = 3'd5;

   logic [2:0] state_ff, state_in;
   skrf_pkg::var_type init_var_ff, meas_noise_ff, proc_noise_ff;
   skrf_pkg::rate_type est_ff, est_in;
   skrf_pkg::rate_type prev_ff, prev_in;
   skrf_pkg::rate_type gyro_ff, gyro_in;
   skrf_pkg::var_type var_ff, var_in;
   logic awaiting_ff, awaiting_in;
   skrf_pkg::var_type p_ff, p_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [GW-1:0] quo_ff, quo_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [GW-1:0] gain_ff, gain_in;
   logic [MW-1:0] mag_ff, mag_in;
   logic neg_ff, neg_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic rsp_valid_ff, rsp_valid_in;
   skrf_pkg::rate_type rsp_rate_ff, rsp_rate_in;
   skrf_pkg::var_type rsp_var_ff, rsp_var_in;

   logic req_fire;
   logic slot_free;
   logic [DW:0] rem_shift;
   logic [DW:0] rem_diff;
   logic [GW-1:0] gain_eff;
   logic signed [DW:0] diff;
   logic [DW:0] p_sum;
   logic signed [SW-1:0] pred_sum;
   logic signed [SW-1:0] apply_sum;
   logic [MW-1:0] corr;
   logic [MW-1:0] mul_a;
   logic [GW-1:0] mul_b;

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_fire = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;
   assign slot_free = !rsp_valid_ff || rsp_if.ready;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.filtered_rate = rsp_rate_ff;
   assign rsp_if.estimate_variance = rsp_var_ff;

   assign pred_sum = SW'(est_ff) + SW'(req_if.rate_sample) - SW'(prev_ff);
   assign p_sum = (DW+1)'(var_ff) + (DW+1)'(proc_noise_ff);
   assign rem_shift = (cnt_ff == '0) ? (DW+1)'(rem_ff) : {rem_ff, 1'b0};
   assign rem_diff = rem_shift - (DW+1)'(den_ff);
   assign gain_eff = (den_ff == '0) ? '0 : quo_ff;
   assign diff = (DW+1)'(gyro_ff) - (DW+1)'(est_ff);
   assign corr = prod_ff[FB +: MW];
   assign apply_sum = neg_ff ? (SW'(est_ff) - SW'({1'b0, corr}))
                             : (SW'(est_ff) + SW'({1'b0, corr}));

   always_comb begin
      if (state_ff == S_MVAR) begin
         mul_a = MW'(p_ff);
         mul_b = GW'(1 << FB) - gain_eff;
      end else begin
         mul_a = mag_ff;
         mul_b = gain_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      est_in = est_ff;
      prev_in = prev_ff;
      gyro_in = gyro_ff;
      var_in = var_ff;
      awaiting_in = awaiting_ff;
      p_in = p_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      gain_in = gain_ff;
      mag_in = mag_ff;
      neg_in = neg_ff;
      prod_in = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_rate_in = rsp_rate_ff;
      rsp_var_in = rsp_var_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_if.opcode == skrf_pkg::OP_GYRO) begin
                  gyro_in = req_if.rate_sample;
               end else if (awaiting_ff) begin
                  est_in = req_if.rate_sample;
                  prev_in = req_if.rate_sample;
                  var_in = init_var_ff;
                  awaiting_in = 1'b0;
               end else begin
                  est_in = skrf_pkg::sat_rate(pred_sum);
                  prev_in = req_if.rate_sample;
                  p_in = p_sum[DW-1] ? {VW{1'b1}} : p_sum[VW-1:0];
                  state_in = S_PREP;
               end
            end
         end
         S_PREP: begin
            den_in = DW'(p_ff) + DW'(meas_noise_ff);
            rem_in = DW'(p_ff);
            quo_in = '0;
            cnt_in = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (!rem_diff[DW]) begin
               rem_in = rem_diff[DW-1:0];
               quo_in = {quo_ff[GW-2:0], 1'b1};
            end else begin
               rem_in = rem_shift[DW-1:0];
               quo_in = {quo_ff[GW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(DIV_STEPS - 1)) begin
               state_in = S_MVAR;
            end
         end
         S_MVAR: begin
            gain_in = gain_eff;
            prod_in = PW'(mul_a) * PW'(mul_b);
            neg_in = diff[DW];
            mag_in = diff[DW] ? MW'(-diff) : MW'(diff);
            state_in = S_MCORR;
         end
         S_MCORR: begin
            var_in = prod_ff[FB +: VW];
            prod_in = PW'(mul_a) * PW'(mul_b);
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (slot_free) begin
               est_in = skrf_pkg::sat_rate(apply_sum);
               rsp_rate_in = skrf_pkg::sat_rate(apply_sum);
               rsp_var_in = var_ff;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         init_var_ff <= skrf_pkg::INIT_VAR_RESET;
         meas_noise_ff <= skrf_pkg::MEAS_NOISE_RESET;
         proc_noise_ff <= skrf_pkg::PROC_NOISE_RESET;
         est_ff <= '0;
         prev_ff <= '0;
         gyro_ff <= '0;
         var_ff <= skrf_pkg::INIT_VAR_RESET;
         awaiting_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         est_ff <= est_in;
         prev_ff <= prev_in;
         gyro_ff <= gyro_in;
         var_ff <= var_in;
         awaiting_ff <= awaiting_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_if.valid && csr_if.ready) begin
            unique case (csr_if.addr)
               skrf_pkg::REG_INIT_VAR:   init_var_ff <= csr_if.wdata;
               skrf_pkg::REG_MEAS_NOISE: meas_noise_ff <= csr_if.wdata;
               skrf_pkg::REG_PROC_NOISE: proc_noise_ff <= csr_if.wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      gain_ff <= gain_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      prod_ff <= prod_in;
      rsp_rate_ff <= rsp_rate_in;
      rsp_var_ff <= rsp_var_in;
   end

endmodule
`default_nettype wire

// ===== sv/skrf_checker.sv =====
// Port-level assertions for the rate fusion filter, bound to its top level.
`default_nettype none
module skrf_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic req_opcode,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [skrf_pkg::DATA_WIDTH-1:0] rsp_rate,
   input wire logic [skrf_pkg::VAR_WIDTH-1:0] rsp_var
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rate) && $stable(rsp_var))
      else $error("Result beat changed while stalled.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result beat present right after reset.");

   a_gyro_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_opcode == skrf_pkg::OP_GYRO && !rsp_valid
      |=> !rsp_valid)
      else $error("Gyro beat produced a result.");

   a_ready_on_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("Sequencer busy when a result appeared.");

endmodule

bind scalar_kalman_rate_fusion skrf_checker u_skrf_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_if.valid),
   .req_ready(req_if.ready),
   .req_opcode(req_if.opcode),
   .rsp_valid(rsp_if.valid),
   .rsp_ready(rsp_if.ready),
   .rsp_rate(rsp_if.filtered_rate),
   .rsp_var(rsp_if.estimate_variance)
);
`default_nettype wire
